// ===== rtl/dsi_pkg.sv =====
// ---------------------------------------------------------------------------
// dsi_pkg
// Shared types and constants of the DVB-T symbol interleaver.
// ---------------------------------------------------------------------------
package dsi_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] IDX_MODE      = 2'd0;
    localparam logic [1:0] IDX_DIRECTION = 2'd1;
    localparam logic [1:0] IDX_FRAME     = 2'd2;

    // position of the last payload cell in a symbol
    localparam logic [12:0] LAST_POS_2K = 13'd1511;
    localparam logic [12:0] LAST_POS_8K = 13'd6047;

    // payload length, upper bound for accepted permutation values
    localparam logic [12:0] PAYLOAD_2K = 13'd1512;
    localparam logic [12:0] PAYLOAD_8K = 13'd6048;

    // reset values of the registers
    localparam logic       MODE_RESET      = 1'b0;
    localparam logic       DIRECTION_RESET = 1'b1;
    localparam logic [6:0] FRAME_RESET     = 7'd68;

    // depth of the output queue
    localparam int FIFO_DEPTH = 4;

    // one accepted item on its way to the cell store
    typedef struct packed {
        logic [7:0]  cell_data;
        logic [12:0] pos;
        logic        wr_scatter;
        logic        rd_scatter;
        logic        bank;
        logic        emit;
        logic        last;
        logic [6:0]  sym;
    } stage_t;

    // status that travels alongside the store read data
    typedef struct packed {
        logic       emit;
        logic       last;
        logic [6:0] sym;
    } status_t;

    // one result item in the output queue
    typedef struct packed {
        logic [7:0] cell_data;
        logic       last;
        logic [6:0] sym;
    } out_item_t;

endpackage

// ===== rtl/dsi_perm_table.sv =====
// ---------------------------------------------------------------------------
// dsi_perm_table
// Builds the permutation table H from the LFSR sequence, one LFSR step per
// cycle, and serves one registered table read per cycle afterwards.
// ---------------------------------------------------------------------------
module dsi_perm_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,      // rebuild request, mode is already valid
    input  logic        mode,
    output logic        building,
    input  logic        rd_en,
    input  logic [12:0] rd_addr,
    output logic [12:0] rd_data
);

    // bit permutations of the LFSR word
    localparam logic [3:0] PERM_2K [10] = '{4'd4, 4'd3, 4'd9, 4'd6, 4'd2,
                                            4'd8, 4'd1, 4'd5, 4'd7, 4'd0};
    localparam logic [3:0] PERM_8K [12] = '{4'd7, 4'd1, 4'd4, 4'd2, 4'd9, 4'd6,
                                            4'd8, 4'd10, 4'd0, 4'd3, 4'd11, 4'd5};

    function automatic logic [12:0] permute(input logic [11:0] v, input logic m);
        logic [12:0] r;
        r = '0;
        if (m) begin
            for (int k = 0; k < 12; k++) begin
                r[PERM_8K[k]] = v[k];
            end
        end else begin
            for (int k = 0; k < 10; k++) begin
                r[PERM_2K[k]] = v[k];
            end
        end
        return r;
    endfunction

    logic [12:0] table_mem [8192];

    logic        building_reg;
    logic [12:0] idx_reg;
    logic [12:0] wr_ptr_reg;
    logic [11:0] lfsr_reg;
    logic [12:0] rd_data_reg;

    logic [11:0] lfsr_next;
    logic        feedback;
    logic [12:0] perm_bits;
    logic [12:0] h_value;
    logic        h_ok;
    logic        idx_end;

    // lfsr value for the current index: two leading zeros, then a seed of one
    always_comb begin
        if (mode) begin
            feedback = lfsr_reg[0] ^ lfsr_reg[1] ^ lfsr_reg[4] ^ lfsr_reg[6];
        end else begin
            feedback = lfsr_reg[0] ^ lfsr_reg[3];
        end
        if (idx_reg < 13'd2) begin
            lfsr_next = '0;
        end else if (idx_reg == 13'd2) begin
            lfsr_next = 12'd1;
        end else if (mode) begin
            lfsr_next = {feedback, lfsr_reg[11:1]};
        end else begin
            lfsr_next = {2'b00, feedback, lfsr_reg[9:1]};
        end
    end

    // candidate value with the alternating top bit, kept when below payload
    always_comb begin
        perm_bits = permute(lfsr_next, mode);
        if (mode) begin
            h_value = {idx_reg[0], perm_bits[11:0]};
            h_ok    = h_value < dsi_pkg::PAYLOAD_8K;
            idx_end = idx_reg == 13'd8191;
        end else begin
            h_value = {2'b00, idx_reg[0], perm_bits[9:0]};
            h_ok    = h_value < dsi_pkg::PAYLOAD_2K;
            idx_end = idx_reg == 13'd2047;
        end
    end

    // build sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            building_reg <= 1'b1;
            idx_reg      <= '0;
            wr_ptr_reg   <= '0;
            lfsr_reg     <= '0;
        end else if (building_reg) begin
            lfsr_reg <= lfsr_next;
            if (h_ok) begin
                wr_ptr_reg <= wr_ptr_reg + 13'd1;
            end
            if (idx_end) begin
                building_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 13'd1;
            end
        end
    end

    // table memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (building_reg && h_ok) begin
            table_mem[wr_ptr_reg] <= h_value;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign building = building_reg;
    assign rd_data  = rd_data_reg;

endmodule

// ===== rtl/dsi_cell_store.sv =====
// ---------------------------------------------------------------------------
// dsi_cell_store
// Ping-pong cell store: forms the scatter or gather addresses of both banks,
// writes the current symbol and reads the previous one in the same cycle.
// ---------------------------------------------------------------------------
module dsi_cell_store #(
    parameter int BANK_DEPTH = 8192,
    parameter int CELL_BITS  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s1_valid,
    input  dsi_pkg::stage_t      s1,
    input  logic [12:0]          perm_h,
    output logic                 s2_valid,
    output dsi_pkg::status_t     s2,
    output logic [CELL_BITS-1:0] rd_cell
);

    localparam int AW  = $clog2(BANK_DEPTH);
    localparam int SAW = $clog2(2 * BANK_DEPTH);
    localparam logic [13:0] DEPTH_W = 14'(BANK_DEPTH);

    logic [CELL_BITS-1:0] store_mem [2 * BANK_DEPTH];

    logic                 s2_valid_reg;
    dsi_pkg::status_t     s2_reg;
    logic [CELL_BITS-1:0] rd_cell_reg;

    logic [12:0]  wr_raw;
    logic [12:0]  rd_raw;
    logic [13:0]  wr_mod;
    logic [13:0]  rd_mod;
    logic [SAW:0] wr_addr_full;
    logic [SAW:0] rd_addr_full;
    logic [SAW-1:0] wr_addr;
    logic [SAW-1:0] rd_addr;

    // scatter writes to H(p) and reads p, gather the other way round
    always_comb begin
        wr_raw = s1.wr_scatter ? perm_h : s1.pos;
        rd_raw = s1.rd_scatter ? s1.pos : perm_h;
    end

    // fold into one bank, value is below four bank depths
    always_comb begin
        wr_mod = {1'b0, wr_raw};
        rd_mod = {1'b0, rd_raw};
        for (int k = 0; k < 3; k++) begin
            if (wr_mod >= DEPTH_W) begin
                wr_mod = wr_mod - DEPTH_W;
            end
            if (rd_mod >= DEPTH_W) begin
                rd_mod = rd_mod - DEPTH_W;
            end
        end
        wr_addr_full = (SAW + 1)'(wr_mod[AW-1:0]);
        rd_addr_full = (SAW + 1)'(rd_mod[AW-1:0]);
        if (s1.bank) begin
            wr_addr_full = wr_addr_full + (SAW + 1)'(BANK_DEPTH);
        end else begin
            rd_addr_full = rd_addr_full + (SAW + 1)'(BANK_DEPTH);
        end
        wr_addr = wr_addr_full[SAW-1:0];
        rd_addr = rd_addr_full[SAW-1:0];
    end

    // write and read always hit opposite banks; items follow in order, so a
    // symbol's last write lands before the next item reads that bank
    always_ff @(posedge aclk) begin
        if (s1_valid) begin
            store_mem[wr_addr] <= s1.cell_data[CELL_BITS-1:0];
            rd_cell_reg        <= store_mem[rd_addr];
            s2_reg             <= '{emit: s1.emit, last: s1.last, sym: s1.sym};
        end
    end

    // read stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;
    assign rd_cell  = rd_cell_reg;

endmodule

// ===== rtl/dsi_out_fifo.sv =====
// ---------------------------------------------------------------------------
// dsi_out_fifo
// Small output queue that decouples the store pipeline from the result
// channel.
// ---------------------------------------------------------------------------
module dsi_out_fifo (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    push,
    input  dsi_pkg::out_item_t                      push_item,
    input  logic                                    pop,
    output logic                                    out_valid,
    output dsi_pkg::out_item_t                      out_item,
    output logic [$clog2(dsi_pkg::FIFO_DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(dsi_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(dsi_pkg::FIFO_DEPTH + 1);

    dsi_pkg::out_item_t slot_reg [dsi_pkg::FIFO_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    // queue slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== rtl/dvbt_symbol_interleaver.sv =====
// ---------------------------------------------------------------------------
// dvbt_symbol_interleaver
// DVB-T inner symbol interleaver for 2k and 8k mode with a ping-pong cell
// store and an internally built permutation table.
//
//   channel   dir  handshake              payload
//   s_        in   s_tvalid / s_tready    s_tdata: in_cell
//   m_        out  m_tvalid / m_tready    m_tdata: out_cell, out_symbol_number
//                                         m_tlast: symbol_last
//   cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One cell per cycle while s_tready is high; a result passes the table read,
// the store read and the output queue after its cell.
// After reset and after every mode write the table is rebuilt, one LFSR step
// per cycle over 2048 indexes in 2k mode, 8192 in 8k mode; no cell is taken then.
// s_tready falls when the four-entry output queue plus results in the store
// pipeline could overflow; configuration writes are taken every cycle.
// ---------------------------------------------------------------------------
module dvbt_symbol_interleaver #(
    parameter int BANK_DEPTH = 8192,
    parameter int CELL_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input cells
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_cell
    // reordered cells
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_cell, [14:8] out_symbol_number, [15] zero
    output logic        m_tlast,    // symbol_last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CW = $clog2(dsi_pkg::FIFO_DEPTH + 1);

    // configuration registers
    logic       mode_reg;
    logic       dir_reg;
    logic [6:0] frame_reg;

    // stream state
    logic [12:0] pos_reg;
    logic [6:0]  sym_reg;
    logic        bank_reg;
    logic        primed_reg;
    logic        cur_scatter_reg;
    logic        prev_scatter_reg;
    logic [6:0]  prev_sym_reg;

    // table read stage
    logic            s1_valid_reg;
    dsi_pkg::stage_t s1_reg;
    dsi_pkg::stage_t s1_next;

    logic        cfg_fire;
    logic        mode_write;
    logic        in_fire;
    logic        building;
    logic [12:0] perm_h;
    logic        s2_valid;
    dsi_pkg::status_t s2;
    logic [CELL_BITS-1:0] rd_cell;
    logic        fifo_push;
    dsi_pkg::out_item_t push_item;
    dsi_pkg::out_item_t head_item;
    logic [CW-1:0] fifo_count;
    logic [CW+1:0] pending;
    logic [12:0] last_pos;
    logic        is_last;
    logic        scatter_now;
    logic [7:0]  sym_inc;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign mode_write = cfg_fire && (cfg_index == dsi_pkg::IDX_MODE);

    // room check: queue fill plus results still in the pipeline
    always_comb begin
        pending = (CW + 2)'(fifo_count)
                + (CW + 2)'(s1_valid_reg && s1_reg.emit)
                + (CW + 2)'(s2_valid && s2.emit);
    end
    assign s_tready = !building && (pending < (CW + 2)'(dsi_pkg::FIFO_DEPTH));
    assign in_fire  = s_tvalid && s_tready;

    // per-cell decode
    always_comb begin
        last_pos    = mode_reg ? dsi_pkg::LAST_POS_8K : dsi_pkg::LAST_POS_2K;
        is_last     = pos_reg == last_pos;
        scatter_now = (pos_reg == '0) ? (sym_reg[0] ^ dir_reg) : cur_scatter_reg;
        sym_inc     = {1'b0, sym_reg} + 8'd1;
        s1_next = '{cell_data: s_tdata, pos: pos_reg, wr_scatter: scatter_now,
                    rd_scatter: prev_scatter_reg, bank: bank_reg,
                    emit: primed_reg, last: is_last, sym: prev_sym_reg};
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= dsi_pkg::MODE_RESET;
            dir_reg   <= dsi_pkg::DIRECTION_RESET;
            frame_reg <= dsi_pkg::FRAME_RESET;
        end else if (cfg_fire) begin
            case (cfg_index)
                dsi_pkg::IDX_MODE:      mode_reg  <= cfg_data[0];
                dsi_pkg::IDX_DIRECTION: dir_reg   <= cfg_data[0];
                dsi_pkg::IDX_FRAME:     frame_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // position, symbol and bank tracking; a mode write restarts the stream
    always_ff @(posedge aclk) begin
        if (!aresetn || mode_write) begin
            pos_reg          <= '0;
            sym_reg          <= '0;
            bank_reg         <= 1'b0;
            primed_reg       <= 1'b0;
            cur_scatter_reg  <= 1'b0;
            prev_scatter_reg <= 1'b0;
            prev_sym_reg     <= '0;
        end else if (in_fire) begin
            cur_scatter_reg <= scatter_now;
            if (is_last) begin
                pos_reg          <= '0;
                bank_reg         <= !bank_reg;
                prev_scatter_reg <= scatter_now;
                prev_sym_reg     <= sym_reg;
                sym_reg          <= (sym_inc >= {1'b0, frame_reg}) ? 7'd0 : sym_inc[6:0];
                primed_reg       <= 1'b1;
            end else begin
                pos_reg <= pos_reg + 13'd1;
            end
        end
    end

    // table read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_reg <= s1_next;
        end
    end

    dsi_perm_table u_perm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mode_write),
        .mode     (mode_reg),
        .building (building),
        .rd_en    (in_fire),
        .rd_addr  (pos_reg),
        .rd_data  (perm_h)
    );

    dsi_cell_store #(
        .BANK_DEPTH (BANK_DEPTH),
        .CELL_BITS  (CELL_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid_reg),
        .s1       (s1_reg),
        .perm_h   (perm_h),
        .s2_valid (s2_valid),
        .s2       (s2),
        .rd_cell  (rd_cell)
    );

    // results of the previous symbol go to the output queue
    assign fifo_push = s2_valid && s2.emit;
    assign push_item = '{cell_data: 8'(rd_cell), last: s2.last, sym: s2.sym};

    dsi_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_item (push_item),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_item  (head_item),
        .count     (fifo_count)
    );

    assign m_tdata = {1'b0, head_item.sym, head_item.cell_data};
    assign m_tlast = head_item.last;

endmodule

// ===== rtl/dsi_checker.sv =====
// ---------------------------------------------------------------------------
// dsi_checker
// Port-level checks of the symbol interleaver, bound to the top level.
// ---------------------------------------------------------------------------
module dsi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index
);

    // a stalled result holds its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // padding bit of the result item stays clear
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15])
        else $error("result padding bit set");

    // reset starts a table build and empties the output queue
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("item channel active right after reset");

    // a mode write starts a table rebuild, so no cell is taken next cycle
    a_mode_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == dsi_pkg::IDX_MODE |=> !s_tready)
        else $error("cell accepted during table rebuild");

endmodule

bind dvbt_symbol_interleaver dsi_checker u_dsi_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

// ===== dv/dvbt_symbol_interleaver_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dvbt_symbol_interleaver_tb
// Self-checking bench for the DVB-T symbol interleaver. A scoreboard class
// keeps its own permutation table and ping-pong cell store, predicts every
// reordered cell from the accepted input cells and compares it with the
// block's output. Phases run 2k and 8k symbols under several register
// settings, with idle and stall patterns on both streams.
// ---------------------------------------------------------------------------
module dvbt_symbol_interleaver_tb;

    localparam int BANK_DEPTH    = 8192;
    localparam int TABLE_DEPTH   = 8192;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int CELLS_2K      = 1512;
    localparam int CELLS_8K      = 6048;

    // index with no register behind it
    localparam logic [1:0] IDX_UNUSED = 2'd3;

    // ---------------------------------------------------------------------
    // scoreboard: interleaver predictor and queue of expected cells
    // ---------------------------------------------------------------------
    class interleave_scoreboard;
        bit          mode;
        bit          direction;
        bit [6:0]    frame_syms;
        bit [12:0]   perm [TABLE_DEPTH];
        bit [7:0]    cell_mem [2*BANK_DEPTH];
        int unsigned cell_pos;
        bit [6:0]    sym_count;
        bit          bank;
        bit          primed;
        bit          cur_scatter;
        bit          prev_scatter;
        bit [6:0]    prev_sym;
        int unsigned wire_2k [10] = '{4, 3, 9, 6, 2, 8, 1, 5, 7, 0};
        int unsigned wire_8k [12] = '{7, 1, 4, 2, 9, 6, 8, 10, 0, 3, 11, 5};
        dsi_pkg::out_item_t expected_cells [$];
        int          mismatches;

        function new();
            mode       = dsi_pkg::MODE_RESET;
            direction  = dsi_pkg::DIRECTION_RESET;
            frame_syms = dsi_pkg::FRAME_RESET;
            mismatches = 0;
            restart();
            build_perm();
        endfunction

        function void restart();
            cell_pos     = 0;
            sym_count    = '0;
            bank         = 1'b0;
            primed       = 1'b0;
            cur_scatter  = 1'b0;
            prev_scatter = 1'b0;
            prev_sym     = '0;
        endfunction

        // lfsr walk with bit wiring, values beyond the payload dropped
        function void build_perm();
            int unsigned nr, nmax, lfsr, q, r, h, nb, i, k, dst;
            nr   = mode ? 13 : 11;
            nmax = mode ? dsi_pkg::PAYLOAD_8K : dsi_pkg::PAYLOAD_2K;
            lfsr = 0;
            q    = 0;
            foreach (perm[j]) perm[j] = '0;
            for (i = 0; i < (32'd1 << nr); i++) begin
                if (i < 2) begin
                    lfsr = 0;
                end else if (i == 2) begin
                    lfsr = 1;
                end else begin
                    if (mode)
                        nb = (lfsr ^ (lfsr >> 1) ^ (lfsr >> 4) ^ (lfsr >> 6)) & 1;
                    else
                        nb = (lfsr ^ (lfsr >> 3)) & 1;
                    lfsr = ((lfsr >> 1) | (nb << (nr - 2))) & ((32'd1 << (nr - 1)) - 1);
                end
                r = 0;
                for (k = 0; k < nr - 1; k++) begin
                    dst = mode ? wire_8k[k] : wire_2k[k];
                    r |= ((lfsr >> k) & 1) << dst;
                end
                h = ((i & 1) << (nr - 1)) + r;
                if (h < nmax && q < TABLE_DEPTH) begin
                    perm[q] = h[12:0];
                    q++;
                end
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                dsi_pkg::IDX_MODE: begin
                    mode = data[0];
                    restart();
                    build_perm();
                end
                dsi_pkg::IDX_DIRECTION: direction  = data[0];
                dsi_pkg::IDX_FRAME:     frame_syms = data[6:0];
                default: ;
            endcase
        endfunction

        // one accepted input cell: store it, queue the released cell
        function void note_cell(bit [7:0] cell_val);
            int unsigned n, last_pos, p, h, waddr, raddr, wbase, rbase;
            dsi_pkg::out_item_t item;
            n        = mode ? dsi_pkg::PAYLOAD_8K : dsi_pkg::PAYLOAD_2K;
            last_pos = mode ? dsi_pkg::LAST_POS_8K : dsi_pkg::LAST_POS_2K;
            p        = cell_pos;
            if (p >= n) p = 0;
            // scatter or gather is fixed on the first cell of a symbol
            if (p == 0) cur_scatter = sym_count[0] ^ direction;
            h     = perm[p % TABLE_DEPTH];
            wbase = bank ? BANK_DEPTH : 0;
            rbase = bank ? 0 : BANK_DEPTH;
            waddr = (cur_scatter ? h : p) % BANK_DEPTH;
            raddr = (prev_scatter ? p : h) % BANK_DEPTH;
            if (primed) begin
                item.cell_data = cell_mem[rbase + raddr];
                item.last      = (p == last_pos);
                item.sym       = prev_sym;
                expected_cells.push_back(item);
            end
            cell_mem[wbase + waddr] = cell_val;
            if (p == last_pos) begin
                cell_pos     = 0;
                bank         = ~bank;
                prev_scatter = cur_scatter;
                prev_sym     = sym_count;
                sym_count    = (sym_count + 1 >= frame_syms) ? 7'd0 : sym_count + 7'd1;
                primed       = 1'b1;
            end else begin
                cell_pos = p + 1;
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // one accepted output cell against the oldest expectation
        function void check_result(logic [15:0] tdata, logic tlast);
            dsi_pkg::out_item_t want;
            if (expected_cells.size() == 0) begin
                flag($sformatf("unexpected cell %0d sym %0d last %0b",
                               tdata[7:0], tdata[14:8], tlast));
            end else begin
                want = expected_cells.pop_front();
                if (tdata[7:0] !== want.cell_data || tdata[14:8] !== want.sym ||
                    tlast !== want.last)
                    flag($sformatf("mismatch: cell %0d/%0d sym %0d/%0d last %0b/%0b (exp/act)",
                                   want.cell_data, tdata[7:0], want.sym, tdata[14:8],
                                   want.last, tlast));
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    interleave_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left     = 0;
    int unsigned cycle_cnt     = 0;

    bit [7:0] corner_cells [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};

    dvbt_symbol_interleaver #(
        .BANK_DEPTH (BANK_DEPTH),
        .CELL_BITS  (8)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("dvbt_symbol_interleaver test failed");
        $finish;
    end

    // receiver: check accepted cells, random stalls, long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one cell, with random idle cycles ahead of it
    task automatic send_cell(input bit [7:0] cell_val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cell_val;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_cell(cell_val);
    endtask

    task automatic send_cells(input int count);
        repeat (count) send_cell(8'($urandom_range(0, 255)));
    endtask

    // stop sending until every expected cell is out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: corner cells first, then random 2k symbols
        send_idle_pct = 8;
        recv_idle_pct = 65;
        foreach (corner_cells[i]) send_cell(corner_cells[i]);
        send_cells(2 * CELLS_2K + 200 - 8);
        drain();

        // receive direction mid-symbol, period lowered to the counter's value
        cfg_write(dsi_pkg::IDX_DIRECTION, 8'h00);
        cfg_write(dsi_pkg::IDX_FRAME, 8'd2);
        send_cells(500);
        hold_left = 400;
        send_cells(2 * CELLS_2K - 500);
        drain();

        // longest period, back to transmit, pause mid-symbol
        cfg_write(dsi_pkg::IDX_FRAME, 8'h7F);
        cfg_write(dsi_pkg::IDX_DIRECTION, 8'h01);
        send_cells(700);
        drain();
        send_cells(2 * CELLS_2K - 700);
        drain();

        // shortest period, write to the unused index
        send_idle_pct = 65;
        recv_idle_pct = 8;
        cfg_write(dsi_pkg::IDX_FRAME, 8'd1);
        cfg_write(IDX_UNUSED, 8'hA5);
        send_cells(2000);
        drain();

        // 8k mode
        cfg_write(dsi_pkg::IDX_MODE, 8'h01);
        cfg_write(dsi_pkg::IDX_DIRECTION, 8'h00);
        cfg_write(dsi_pkg::IDX_FRAME, 8'd3);
        send_cells(2 * CELLS_8K + 300);
        drain();

        // back to 2k with upper data bits set, period of zero
        cfg_write(dsi_pkg::IDX_MODE, 8'hFE);
        cfg_write(dsi_pkg::IDX_DIRECTION, 8'hFF);
        cfg_write(dsi_pkg::IDX_FRAME, 8'h80);
        send_cells(2 * CELLS_2K + 500);
        drain();

        // no idling, restart with random settings
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(dsi_pkg::IDX_MODE, 8'h00);
        cfg_write(dsi_pkg::IDX_DIRECTION, 8'($urandom_range(0, 1)));
        cfg_write(dsi_pkg::IDX_FRAME, 8'($urandom_range(1, 6)));
        send_cells(3 * CELLS_2K + int'($urandom_range(0, 200)));
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("dvbt_symbol_interleaver test passed");
        end else begin
            $display("dvbt_symbol_interleaver test failed");
        end
        $finish;
    end

endmodule
